// ===== hw/rtl/digitizer_aggregate_stream_parser_core_macros.svh =====
// Assertion macros shared by the stream parser modules
`ifndef DIGITIZER_AGGREGATE_STREAM_PARSER_CORE_MACROS_SVH
`define DIGITIZER_AGGREGATE_STREAM_PARSER_CORE_MACROS_SVH

// property must hold at every clock edge outside reset
`define DASP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define DASP_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/dasp_pkg.sv =====
// Types and constants shared by the stream parser modules
`timescale 1ns / 1ps

package dasp_pkg;

	localparam int CHANNELS = 16;
	localparam int GROUPS = (CHANNELS / 2 > 8) ? 8 : CHANNELS / 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int DIV_STEPS = 31;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [4:0] CLOCK_RES_RESET = 5'd2;
	localparam logic [3:0] BOARD_MARKER = 4'hA;

	localparam logic RESULT_EVENT = 1'b0;
	localparam logic RESULT_MARKER_ERROR = 1'b1;

	typedef struct packed {
		logic [31:0] data_word;
		logic [7:0]  packet_board;
		logic        packet_start;
		logic        marker_bad;
	} qitem_t;

endpackage

// ===== hw/rtl/dasp_front.sv =====
// Front end: accepts packet words, flags the board marker, queues them
`timescale 1ns / 1ps
`include "digitizer_aggregate_stream_parser_core_macros.svh"

module dasp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         data_word,
	input  logic [7:0]          packet_board,
	input  logic                packet_start,
	output logic                q_valid,
	output dasp_pkg::qitem_t    q_item,
	input  logic                q_pop
);

	dasp_pkg::qitem_t mem_q [dasp_pkg::QUEUE_DEPTH];
	logic [dasp_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [dasp_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [dasp_pkg::QCNT_W-1:0] count_q;
	logic push;
	logic pop;
	dasp_pkg::qitem_t new_item;

	always_comb begin
		in_stall = (count_q == dasp_pkg::QCNT_W'(dasp_pkg::QUEUE_DEPTH));
		push = in_valid && !in_stall;
		q_valid = (count_q != '0);
		pop = q_pop && q_valid;
		q_item = mem_q[rd_ptr_q];
		new_item.data_word = data_word;
		new_item.packet_board = packet_board;
		new_item.packet_start = packet_start;
		new_item.marker_bad = (data_word[31:28] != dasp_pkg::BOARD_MARKER);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`DASP_ASSERT_NEVER(a_count_range, count_q > dasp_pkg::QCNT_W'(dasp_pkg::QUEUE_DEPTH), "queue overfilled")
	`DASP_ASSERT(a_push_grows, (push && !pop) |=> (count_q == $past(count_q) + 1'b1), "push lost")

endmodule

// ===== hw/rtl/dasp_div.sv =====
// Restoring divider, one quotient bit per cycle, for the event count
`timescale 1ns / 1ps

module dasp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] dividend,
	input  logic [18:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [30:0] quotient
);

	logic [19:0] rem_q;
	logic [30:0] quo_q;
	logic [18:0] dvs_q;
	logic [dasp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [19:0] rem_sh;
	logic [20:0] diff;
	logic ge;

	always_comb begin
		rem_sh = {rem_q[18:0], quo_q[30]};
		diff = {1'b0, rem_sh} - {2'b00, dvs_q};
		ge = !diff[20];
		busy = busy_q;
		done = done_q;
		quotient = quo_q;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[19:0] : rem_sh;
			quo_q <= {quo_q[29:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= dasp_pkg::DIV_CNT_W'(dasp_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/dasp_back.sv =====
// Back end: walks the aggregate layout and builds the result transaction
`timescale 1ns / 1ps
`include "digitizer_aggregate_stream_parser_core_macros.svh"

module dasp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [4:0]          cfg_wr_data,
	input  logic                q_valid,
	input  dasp_pkg::qitem_t    q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                result_kind,
	output logic [7:0]          board_number,
	output logic [22:0]         event_counter,
	output logic [3:0]          channel_number,
	output logic [50:0]         timestamp,
	output logic [14:0]         energy,
	output logic [15:0]         baseline_quarters,
	output logic                pileup_rollover,
	output logic [4:0]          extras_code,
	output logic [30:0]         aggregate_size
);

	typedef enum logic [3:0] {
		PH_BH0,
		PH_BH1,
		PH_BH2,
		PH_BH3,
		PH_CH0,
		PH_CH1,
		PH_TAG,
		PH_SMP,
		PH_EX2,
		PH_EX1,
		PH_DIV
	} phase_t;

	typedef struct packed {
		logic       found;
		logic [2:0] idx;
	} seek_t;

	function automatic seek_t next_group(input logic [7:0] mask, input logic [3:0] first);
		seek_t r;
		r.found = 1'b0;
		r.idx = '0;
		for (int g = 0; g < dasp_pkg::GROUPS; g++) begin
			if (!r.found && mask[g] && (4'(g) >= first)) begin
				r.found = 1'b1;
				r.idx = 3'(g);
			end
		end
		return r;
	endfunction

	phase_t phase_q;
	phase_t cur_ph;
	logic [4:0]  clock_res_q;
	logic [7:0]  mask_q;
	logic [2:0]  gidx_q;
	logic [22:0] counter_q;
	logic [30:0] size_q;
	logic [17:0] spw_q;
	logic [17:0] swl_q;
	logic [30:0] events_q;
	logic [3:0]  chan_q;
	logic [30:0] tag_q;
	logic [31:0] extras_q;
	logic        out_valid_q;

	logic pop;
	logic out_free;
	seek_t seek_first;
	seek_t seek_next;
	logic [17:0] spw_new;
	logic [46:0] ticks;
	logic [51:0] product;
	logic [30:0] events_dec;
	logic [17:0] swl_dec;
	logic size_small;
	logic div_start;
	logic div_busy;
	logic div_done;
	logic [30:0] div_quot;

	always_comb begin
		cur_ph = q_item.packet_start ? PH_BH0 : phase_q;
		out_free = !out_valid_q || !out_stall;
		pop = q_valid && (phase_q != PH_DIV) && out_free;
		q_pop = pop;
		out_valid = out_valid_q;
		seek_first = next_group(mask_q, 4'd0);
		seek_next = next_group(mask_q, {1'b0, gidx_q} + 4'd1);
		spw_new = {q_item.data_word[15:0], 2'b00};
		ticks = {extras_q[31:16], tag_q};
		product = {5'd0, ticks} * {47'd0, clock_res_q};
		events_dec = events_q - 1'b1;
		swl_dec = swl_q - 1'b1;
		size_small = (size_q < 31'd2);
		div_start = pop && (cur_ph == PH_CH1) && !size_small;
	end

	dasp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (size_q - 31'd2),
		.divisor  ({1'b0, spw_new} + 19'd3),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BH0;
			clock_res_q <= dasp_pkg::CLOCK_RES_RESET;
			mask_q <= '0;
			gidx_q <= '0;
			counter_q <= '0;
			size_q <= '0;
			spw_q <= '0;
			swl_q <= '0;
			events_q <= '0;
			chan_q <= '0;
			tag_q <= '0;
			extras_q <= '0;
			out_valid_q <= 1'b0;
			result_kind <= dasp_pkg::RESULT_EVENT;
			board_number <= '0;
			event_counter <= '0;
			channel_number <= '0;
			timestamp <= '0;
			energy <= '0;
			baseline_quarters <= '0;
			pileup_rollover <= 1'b0;
			extras_code <= '0;
			aggregate_size <= '0;
		end else begin
			if (cfg_wr_en) begin
				clock_res_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if ((phase_q == PH_DIV) && div_done) begin
				events_q <= div_quot;
				if (div_quot != '0) begin
					phase_q <= PH_TAG;
				end else if (seek_next.found) begin
					gidx_q <= seek_next.idx;
					phase_q <= PH_CH0;
				end else begin
					phase_q <= PH_BH0;
				end
			end
			if (pop) begin
				unique case (cur_ph)
					PH_BH0: begin
						if (q_item.marker_bad) begin
							out_valid_q <= 1'b1;
							result_kind <= dasp_pkg::RESULT_MARKER_ERROR;
							board_number <= q_item.packet_board;
							event_counter <= '0;
							channel_number <= '0;
							timestamp <= '0;
							energy <= '0;
							baseline_quarters <= '0;
							pileup_rollover <= 1'b0;
							extras_code <= '0;
							aggregate_size <= '0;
						end
						phase_q <= PH_BH1;
					end
					PH_BH1: begin
						mask_q <= q_item.data_word[7:0];
						gidx_q <= '0;
						phase_q <= PH_BH2;
					end
					PH_BH2: begin
						counter_q <= q_item.data_word[22:0];
						phase_q <= PH_BH3;
					end
					PH_BH3: begin
						if (seek_first.found) begin
							gidx_q <= seek_first.idx;
							phase_q <= PH_CH0;
						end else begin
							phase_q <= PH_BH0;
						end
					end
					PH_CH0: begin
						size_q <= q_item.data_word[30:0];
						phase_q <= PH_CH1;
					end
					PH_CH1: begin
						spw_q <= spw_new;
						if (!size_small) begin
							phase_q <= PH_DIV;
						end else begin
							events_q <= '0;
							if (seek_next.found) begin
								gidx_q <= seek_next.idx;
								phase_q <= PH_CH0;
							end else begin
								phase_q <= PH_BH0;
							end
						end
					end
					PH_TAG: begin
						chan_q <= {gidx_q, q_item.data_word[31]};
						tag_q <= q_item.data_word[30:0];
						swl_q <= spw_q;
						phase_q <= (spw_q == '0) ? PH_EX2 : PH_SMP;
					end
					PH_SMP: begin
						swl_q <= swl_dec;
						if (swl_dec == '0) begin
							phase_q <= PH_EX2;
						end
					end
					PH_EX2: begin
						extras_q <= q_item.data_word;
						phase_q <= PH_EX1;
					end
					PH_EX1: begin
						out_valid_q <= 1'b1;
						result_kind <= dasp_pkg::RESULT_EVENT;
						board_number <= q_item.packet_board;
						event_counter <= counter_q;
						channel_number <= chan_q;
						timestamp <= product[51] ? '1 : product[50:0];
						energy <= q_item.data_word[14:0];
						baseline_quarters <= extras_q[15:0];
						pileup_rollover <= q_item.data_word[15];
						extras_code <= q_item.data_word[20:16];
						aggregate_size <= size_q;
						events_q <= events_dec;
						if (events_dec != '0) begin
							phase_q <= PH_TAG;
						end else if (seek_next.found) begin
							gidx_q <= seek_next.idx;
							phase_q <= PH_CH0;
						end else begin
							phase_q <= PH_BH0;
						end
					end
					default: begin
						phase_q <= PH_BH0;
					end
				endcase
			end
		end
	end

	`DASP_ASSERT(a_result_from_pop, $rose(out_valid_q) |-> $past(pop), "result without a word")
	`DASP_ASSERT(a_div_tracked, (phase_q == PH_DIV) |-> (div_busy || div_done), "divider lost")

endmodule

// ===== hw/rtl/digitizer_aggregate_stream_parser_core.sv =====
// Top level of the digitizer board aggregate stream parser
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------
//   input   | in_valid/in_stall  | data_word, packet_board, packet_start
//   result  | out_valid/out_stall| result_kind ... aggregate_size
//   config  | cfg_wr_en          | cfg_wr_data (clock resolution)
//
// One word per cycle through the four-entry queue and the parse unit, unless
// stalled. The second channel aggregate header word with a size of two or
// more starts the restoring divider for the event count and holds the parse
// unit until it is done. A result is registered when its last word is popped.
// arst_n empties the queue, returns to the board header, sets resolution to 2.
// in_stall rises when the queue is full; out_stall holds the parse unit.
`timescale 1ns / 1ps

module digitizer_aggregate_stream_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [7:0]  packet_board,
	input  logic        packet_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [7:0]  board_number,
	output logic [22:0] event_counter,
	output logic [3:0]  channel_number,
	output logic [50:0] timestamp,
	output logic [14:0] energy,
	output logic [15:0] baseline_quarters,
	output logic        pileup_rollover,
	output logic [4:0]  extras_code,
	output logic [30:0] aggregate_size
);

	logic q_valid;
	logic q_pop;
	dasp_pkg::qitem_t q_item;

	dasp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_word    (data_word),
		.packet_board (packet_board),
		.packet_start (packet_start),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	dasp_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.q_valid           (q_valid),
		.q_item            (q_item),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.result_kind       (result_kind),
		.board_number      (board_number),
		.event_counter     (event_counter),
		.channel_number    (channel_number),
		.timestamp         (timestamp),
		.energy            (energy),
		.baseline_quarters (baseline_quarters),
		.pileup_rollover   (pileup_rollover),
		.extras_code       (extras_code),
		.aggregate_size    (aggregate_size)
	);

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the digitizer board aggregate stream parser
`timescale 1ns / 1ps

module testbench;

	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES = 400;
	localparam logic [63:0] TS_MAX = (64'd1 << 51) - 64'd1;

	typedef enum logic [3:0] {
		PH_BOARD0, PH_BOARD1, PH_BOARD2, PH_BOARD3, PH_CHAN0, PH_CHAN1,
		PH_TAG, PH_SAMPLES, PH_EXTRA2, PH_EXTRA1
	} parse_phase_t;

	typedef struct {
		logic        kind;
		logic [7:0]  board;
		logic [22:0] counter;
		logic [3:0]  chan;
		logic [50:0] ts;
		logic [14:0] energy;
		logic [15:0] baseline;
		logic        pileup;
		logic [4:0]  code;
		logic [30:0] size;
	} event_record_t;

	typedef struct {
		logic [31:0] word;
		logic [7:0]  board;
		logic        start;
	} packet_word_t;

	class event_tracker;
		logic [4:0]   clock_res = dasp_pkg::CLOCK_RES_RESET;
		parse_phase_t phase = PH_BOARD0;
		logic [7:0]   mask = '0;
		logic [2:0]   group = '0;
		logic [22:0]  counter = '0;
		logic [30:0]  agg_size = '0;
		logic [17:0]  samples_per_event = '0;
		logic [17:0]  samples_left = '0;
		logic [30:0]  events_left = '0;
		logic [3:0]   chan = '0;
		logic [30:0]  tag = '0;
		logic [31:0]  extras = '0;
		event_record_t pending_events[$];
		int errors = 0;

		function void seek_group(int first);
			for (int g = first; g < dasp_pkg::GROUPS; g++) begin
				if (mask[g]) begin
					group = g[2:0];
					phase = PH_CHAN0;
					return;
				end
			end
			phase = PH_BOARD0;
		endfunction

		function void decode_word(logic [31:0] w, logic [7:0] b, logic s);
			event_record_t r;
			logic [46:0] ticks;
			logic [63:0] prod;
			r = '{default: '0};
			if (s)
				phase = PH_BOARD0;
			case (phase)
				PH_BOARD0: begin
					if (w[31:28] != dasp_pkg::BOARD_MARKER) begin
						r.kind = dasp_pkg::RESULT_MARKER_ERROR;
						r.board = b;
						pending_events.insert(pending_events.size(), r);
					end
					phase = PH_BOARD1;
				end
				PH_BOARD1: begin
					mask = w[7:0];
					group = '0;
					phase = PH_BOARD2;
				end
				PH_BOARD2: begin
					counter = w[22:0];
					phase = PH_BOARD3;
				end
				PH_BOARD3: seek_group(0);
				PH_CHAN0: begin
					agg_size = w[30:0];
					phase = PH_CHAN1;
				end
				PH_CHAN1: begin
					samples_per_event = {w[15:0], 2'b00};
					if (agg_size < 31'd2)
						events_left = '0;
					else
						events_left = 31'((32'(agg_size) - 32'd2) /
							(32'(samples_per_event) + 32'd3));
					if (events_left == '0)
						seek_group(int'(group) + 1);
					else
						phase = PH_TAG;
				end
				PH_TAG: begin
					chan = {group, w[31]};
					tag = w[30:0];
					samples_left = samples_per_event;
					phase = (samples_left == '0) ? PH_EXTRA2 : PH_SAMPLES;
				end
				PH_SAMPLES: begin
					samples_left = samples_left - 18'd1;
					if (samples_left == '0)
						phase = PH_EXTRA2;
				end
				PH_EXTRA2: begin
					extras = w;
					phase = PH_EXTRA1;
				end
				PH_EXTRA1: begin
					ticks = {extras[31:16], tag};
					prod = 64'(ticks) * 64'(clock_res);
					if (prod > TS_MAX)
						prod = TS_MAX;
					r.kind = dasp_pkg::RESULT_EVENT;
					r.board = b;
					r.counter = counter;
					r.chan = chan;
					r.ts = prod[50:0];
					r.energy = w[14:0];
					r.baseline = extras[15:0];
					r.pileup = w[15];
					r.code = w[20:16];
					r.size = agg_size;
					pending_events.insert(pending_events.size(), r);
					events_left = events_left - 31'd1;
					if (events_left != '0)
						phase = PH_TAG;
					else
						seek_group(int'(group) + 1);
				end
				default: phase = PH_BOARD0;
			endcase
		endfunction

		function void compare(string name, logic [63:0] e, logic [63:0] a);
			if (e !== a) begin
				$display("%0t: %s mismatch expected %h actual %h", $time, name, e, a);
				errors++;
			end
		endfunction

		function void match_event(event_record_t act);
			event_record_t e;
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected result expected none actual kind %0d board %h",
					$time, act.kind, act.board);
				errors++;
				return;
			end
			e = pending_events.pop_front();
			compare("result_kind", 64'(e.kind), 64'(act.kind));
			compare("board_number", 64'(e.board), 64'(act.board));
			compare("event_counter", 64'(e.counter), 64'(act.counter));
			compare("channel_number", 64'(e.chan), 64'(act.chan));
			compare("timestamp", 64'(e.ts), 64'(act.ts));
			compare("energy", 64'(e.energy), 64'(act.energy));
			compare("baseline_quarters", 64'(e.baseline), 64'(act.baseline));
			compare("pileup_rollover", 64'(e.pileup), 64'(act.pileup));
			compare("extras_code", 64'(e.code), 64'(act.code));
			compare("aggregate_size", 64'(e.size), 64'(act.size));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [4:0]  cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] data_word = '0;
	logic [7:0]  packet_board = '0;
	logic        packet_start = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        result_kind;
	logic [7:0]  board_number;
	logic [22:0] event_counter;
	logic [3:0]  channel_number;
	logic [50:0] timestamp;
	logic [14:0] energy;
	logic [15:0] baseline_quarters;
	logic        pileup_rollover;
	logic [4:0]  extras_code;
	logic [30:0] aggregate_size;

	event_tracker tracker = new;
	packet_word_t word_q[$];
	logic [7:0]   pkt_board = '0;
	bit           calm = 1'b0;
	bit           hold_req = 1'b0;
	int           hold_left = 0;
	int           quiet_cycles = 0;

	digitizer_aggregate_stream_parser_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_word        (data_word),
		.packet_board     (packet_board),
		.packet_start     (packet_start),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_kind      (result_kind),
		.board_number     (board_number),
		.event_counter    (event_counter),
		.channel_number   (channel_number),
		.timestamp        (timestamp),
		.energy           (energy),
		.baseline_quarters(baseline_quarters),
		.pileup_rollover  (pileup_rollover),
		.extras_code      (extras_code),
		.aggregate_size   (aggregate_size)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function void push_word(logic [31:0] w, logic s);
		word_q.insert(word_q.size(), '{word: w, board: pkt_board, start: s});
	endfunction

	function void add_packet(bit marker_ok, logic [7:0] mask, int max_events, int max_field);
		logic [3:0] nib;
		int field;
		int sw;
		int nev;
		int size;
		pkt_board = 8'($urandom);
		nib = 4'($urandom_range(0, 14));
		if (nib >= dasp_pkg::BOARD_MARKER)
			nib = nib + 4'd1;
		push_word({marker_ok ? dasp_pkg::BOARD_MARKER : nib, 28'($urandom)}, 1'b1);
		push_word({24'($urandom), mask}, 1'b0);
		push_word($urandom, 1'b0);
		push_word($urandom, 1'b0);
		for (int g = 0; g < dasp_pkg::GROUPS; g++) begin
			if (mask[g]) begin
				field = $urandom_range(0, max_field);
				sw = field * 4;
				nev = $urandom_range(0, max_events);
				if (nev == 0 && $urandom_range(0, 1))
					size = $urandom_range(0, 1);
				else
					size = 2 + nev * (sw + 3) + $urandom_range(0, sw + 2);
				push_word({1'($urandom), 31'(size)}, 1'b0);
				push_word({16'($urandom), 16'(field)}, 1'b0);
				repeat (nev) begin
					push_word($urandom, 1'b0);
					repeat (sw) push_word($urandom, 1'b0);
					push_word($urandom, 1'b0);
					push_word($urandom, 1'b0);
				end
			end
		end
	endfunction

	task automatic send_word(packet_word_t s);
		while (!calm && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_word <= s.word;
		packet_board <= s.board;
		packet_start <= s.start;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.decode_word(s.word, s.board, s.start);
	endtask

	task automatic flush_words();
		while (word_q.size() > 0)
			send_word(word_q.pop_front());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_resolution(logic [4:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.clock_res = value;
	endtask

	task automatic run_random(int n_items);
		int r;
		int keep;
		while (n_items > 0) begin
			r = $urandom_range(0, 99);
			if (r < 85) begin
				add_packet($urandom_range(0, 9) != 0, 8'($urandom), 3, 2);
				if (r >= 70) begin
					keep = $urandom_range(1, word_q.size());
					while (word_q.size() > keep)
						void'(word_q.pop_back());
				end
			end else begin
				pkt_board = 8'($urandom);
				repeat ($urandom_range(1, 6))
					push_word($urandom, $urandom_range(0, 7) == 0);
			end
			n_items -= word_q.size();
			flush_words();
		end
	endtask

	task automatic run_directed();
		pkt_board = 8'h00;
		push_word(32'h0000_0000, 1'b1);
		push_word(32'hFFFF_FF00, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		pkt_board = 8'hFF;
		push_word(32'hAFFF_FFFF, 1'b1);
		push_word(32'hFFFF_FF81, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b0);
		push_word(32'h8000_0001, 1'b0);
		push_word(32'hFFFF_0000, 1'b0);
		push_word(32'h0000_0005, 1'b0);
		push_word(32'hFFFF_0000, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b0);
		pkt_board = 8'h5A;
		push_word(32'hA000_0000, 1'b1);
		push_word(32'h0000_0002, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word(32'h7FFF_FFFF, 1'b0);
		push_word(32'h0000_0001, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		repeat (4) push_word(32'h0000_0000, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		flush_words();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(400);
		drain();
		write_resolution(5'd16);
		hold_req = 1'b1;
		run_random(500);
		drain();
		write_resolution(5'd1);
		run_random(250);
		drain();
		run_random(250);
		drain();
		write_resolution(5'($urandom_range(1, 16)));
		calm = 1'b1;
		run_random(300);
		calm = 1'b0;
		run_random(250);
		drain();
		if (tracker.errors == 0 && tracker.pending_events.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 17);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.match_event('{
				kind: result_kind, board: board_number, counter: event_counter,
				chan: channel_number, ts: timestamp, energy: energy,
				baseline: baseline_quarters, pileup: pileup_rollover,
				code: extras_code, size: aggregate_size});
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dasp_pkg.sv
hw/rtl/dasp_front.sv
hw/rtl/dasp_div.sv
hw/rtl/dasp_back.sv
hw/rtl/digitizer_aggregate_stream_parser_core.sv
dv/testbench.sv
